@@ rtl/hrl_pkg.sv @@
// Package for the hashed per-key rate limiter: item structs, widths and codes.
// Depends on nothing; every other file imports it.
package hrl_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TIME_W = 31;
    localparam int IDX_W  = 6;
    localparam int KEY_W  = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Item kinds carried in the action field.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_REQ  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key_low;
        logic [KEY_W-1:0]  key_high;
        logic [TIME_W-1:0] min_gap_ms;
        logic              force_req;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] granted_time;
        logic [IDX_W-1:0]  slot_index;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] stamp;
    } t_slot_wr;

endpackage

@@ rtl/hrl_hash.sv @@
// Key hash: folds the four 32-bit key words into a slot number.
// Depends on hrl_pkg.
module hrl_hash
    import hrl_pkg::*;
(
    input  logic [KEY_W-1:0]  i_key_low,
    input  logic [KEY_W-1:0]  i_key_high,
    output logic [SLOT_W-1:0] o_slot
);

    logic [31:0] w [4];
    logic [31:0] h;
    logic [31:0] r16;
    logic [31:0] r10;

    assign w[0] = i_key_low[31:0];
    assign w[1] = i_key_low[63:32];
    assign w[2] = i_key_high[31:0];
    assign w[3] = i_key_high[63:32];

    // The second mix term is not a true rotate: two bit positions overlap and are ORed.
    always_comb begin
        h   = w[0];
        r16 = '0;
        r10 = '0;
        for (int i = 0; i < 4; i++) begin
            r16 = {w[i][15:0], w[i][31:16]};
            r10 = (w[i] >> 20) | (w[i] << 10);
            h   = h ^ (32'd13 * r16) ^ (32'd113 * r10);
        end
    end

    // The slot count is a power of two, so the modulo is a mask.
    assign o_slot = h[SLOT_W-1:0];

endmodule

@@ rtl/hrl_slot_table.sv @@
// Slot table: grant-time memory with a registered read port and per-slot used flags.
// Depends on hrl_pkg.
module hrl_slot_table
    import hrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_slot,
    input  t_slot_wr          i_wr,
    output logic [TIME_W-1:0] o_rd_time,
    output logic              o_rd_used
);

    logic [TIME_W-1:0] r_mem [SLOTS];
    logic [TIME_W-1:0] r_rd_time;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [SLOTS-1:0]  r_used;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.stamp;
        end
        if (i_rd_en) begin
            r_rd_time <= r_mem[i_rd_slot];
            r_rd_slot <= i_rd_slot;
        end
    end

    // The used flags are flip-flops, so they are always current.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[i_wr.slot] <= 1'b1;
        end
    end

    assign o_rd_time = r_rd_time;
    assign o_rd_used = r_used[r_rd_slot];

endmodule

@@ rtl/hashed_per_key_rate_limiter_unit.sv @@
// Top level of the hashed per-key rate limiter: input stage, decision logic, result register.
// Depends on hrl_pkg, hrl_hash and hrl_slot_table.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall| o_out_item (t_out_item)
//
// One item is taken every cycle while the input is not stalled. An accepted request
// passes through the decision stage, whose slot time comes from the registered memory
// read, and then through the result register. A tick gives no result.
// Reset is synchronous and active low; it clears the millisecond counter, the stage valids
// and all 64 slot used flags at once, so no clearing pass is needed.
// A stall on the output holds the result register; a request waiting behind it then
// stalls the input, while a tick in the decision stage still completes.
module hashed_per_key_rate_limiter_unit
    import hrl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Decision stage registers.
    logic              r_s1_valid;
    logic              r_s1_action;
    logic [TIME_W-1:0] r_s1_gap;
    logic              r_s1_force;
    logic [SLOT_W-1:0] r_s1_slot;
    // Bypass for a slot written by the item just ahead of this one.
    logic              r_fwd;
    logic [TIME_W-1:0] r_fwd_time;

    logic [TIME_W-1:0] r_ms;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              accept;
    logic              fire;
    logic              out_free;
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] rd_time;
    logic              rd_used;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] now;
    logic              grant;
    t_slot_wr          slot_wr;
    logic              n_fwd;

    hrl_hash u_hash (
        .i_key_low  (i_in_item.key_low),
        .i_key_high (i_in_item.key_high),
        .o_slot     (in_slot)
    );

    hrl_slot_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_slot (in_slot),
        .i_wr      (slot_wr),
        .o_rd_time (rd_time),
        .o_rd_used (rd_used)
    );

    // The result register can take a new result when empty or being emptied.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && ((r_s1_action == ACT_TICK) || out_free);
    assign o_in_stall = r_s1_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    // A counter of zero still counts as time one, so a grant never returns zero.
    assign now       = (r_ms == '0) ? TIME_W'(1) : r_ms;
    assign last_time = r_fwd ? r_fwd_time : rd_time;

    // The sum is one bit wider than a time, so it cannot wrap.
    assign grant = r_s1_force || (r_s1_gap == '0) || !rd_used ||
                   (({1'b0, last_time} + {1'b0, r_s1_gap}) <= {1'b0, now});

    assign slot_wr.en    = fire && (r_s1_action == ACT_REQ) && grant;
    assign slot_wr.slot  = r_s1_slot;
    assign slot_wr.stamp = now;

    // The memory read taken at this edge misses the write at the same edge.
    assign n_fwd = slot_wr.en && (r_s1_slot == in_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_action <= i_in_item.action;
            r_s1_gap    <= i_in_item.min_gap_ms;
            r_s1_force  <= i_in_item.force_req;
            r_s1_slot   <= in_slot;
            r_fwd       <= n_fwd;
            r_fwd_time  <= now;
        end
    end

    // The millisecond counter saturates at its largest value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= '0;
        end else if (fire && (r_s1_action == ACT_TICK) && (r_ms != TIME_MAX)) begin
            r_ms <= r_ms + TIME_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && (r_s1_action == ACT_REQ)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire && (r_s1_action == ACT_REQ)) begin
            r_out_item.granted_time <= grant ? now : '0;
            r_out_item.slot_index   <= IDX_W'(r_s1_slot);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/hrl_checker.sv @@
// Port-level checker for the rate limiter, bound to the top level.
// Depends on hrl_pkg and hashed_per_key_rate_limiter_unit.
module hrl_checker
    import hrl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic forced_acc;

    assign forced_acc = i_in_valid && !o_in_stall && (i_in_item.action == ACT_REQ) &&
                        i_in_item.force_req;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    a_no_stall_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output is free");

    a_force_grants: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        forced_acc ##1 !i_out_stall |=> o_out_valid && (o_out_item.granted_time != '0))
        else $error("forced request not granted in time");

endmodule

bind hashed_per_key_rate_limiter_unit hrl_checker u_hrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
